>>> rtl/core/bgl_pkg.sv
// Shared types and constants for the bitmap glyph layout block.
// Used by every module under rtl/core but bgl_ram; depends on nothing else.
package bgl_pkg;

	// Command codes on the input channel.
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_CHAR  = 2'd1;
	localparam logic [1:0] CMD_TABLE = 2'd2;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	// Register indexes (word address) on the configuration port.
	localparam logic [2:0] REG_GLYPH_WIDTH   = 3'd0;
	localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_FIRST_CODE    = 3'd2;
	localparam logic [2:0] REG_GLYPH_COUNT   = 3'd3;
	localparam logic [2:0] REG_ATLAS_COLUMNS = 3'd4;
	localparam logic [2:0] REG_DRAW_SCALE    = 3'd5;

	// Register reset values.
	localparam logic [6:0]  RST_GLYPH_WIDTH   = 7'd8;
	localparam logic [6:0]  RST_GLYPH_HEIGHT  = 7'd12;
	localparam logic [7:0]  RST_FIRST_CODE    = 8'd32;
	localparam logic [8:0]  RST_GLYPH_COUNT   = 9'd96;
	localparam logic [8:0]  RST_ATLAS_COLUMNS = 9'd16;
	localparam logic [15:0] RST_DRAW_SCALE    = 16'd256;

	// Quotient bits the column/row divider resolves per cycle.
	localparam int DIV_STEPS = 4;

	typedef enum logic [2:0] {
		KIND_START,
		KIND_TABLE,
		KIND_NEWLINE,
		KIND_GLYPH,
		KIND_SKIP
	} kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV_A,
		BK_DIV_B,
		BK_EMIT
	} bk_state_t;

	// Configuration as seen by the front and back ends, with the scaled
	// cell sizes precomputed.
	typedef struct packed {
		logic [6:0]  glyph_width;
		logic [6:0]  glyph_height;
		logic [7:0]  first_code;
		logic [8:0]  glyph_count;
		logic [8:0]  atlas_columns;
		logic [15:0] draw_scale;
		logic [22:0] width_scaled;
		logic [22:0] height_scaled;
	} cfg_t;

	// One classified command waiting for the back end.
	typedef struct packed {
		kind_t              kind;
		logic [6:0]         code;
		logic [6:0]         idx;
		logic [7:0]         adv;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
	} q_entry_t;

endpackage

>>> rtl/core/bgl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the advance width store.
module bgl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/bgl_front.sv
// Front end: accepts input transfers and classifies each command.
// Depends on bgl_pkg; feeds bgl_queue.
module bgl_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [7:0]         char_code,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic [6:0]         table_index,
	input  logic [7:0]         advance_width,
	input  bgl_pkg::cfg_t      cfg,
	input  logic               q_full,
	output logic               push,
	output bgl_pkg::q_entry_t  entry
);

	logic       known_cmd;
	logic [7:0] diff;
	logic       in_range;

	assign in_ready  = !q_full;
	assign known_cmd = (cmd == bgl_pkg::CMD_START) || (cmd == bgl_pkg::CMD_CHAR)
		|| (cmd == bgl_pkg::CMD_TABLE);
	// Unknown commands are taken and dropped here.
	assign push = in_valid && in_ready && known_cmd;

	// Codes with the top bit set are negative as signed bytes, never in range.
	assign diff     = char_code - cfg.first_code;
	assign in_range = !char_code[7] && (char_code >= cfg.first_code)
		&& ({1'b0, diff} < cfg.glyph_count);

	always_comb begin
		entry.code  = char_code[6:0];
		entry.idx   = diff[6:0];
		entry.adv   = advance_width;
		entry.pos_x = pos_x;
		entry.pos_y = pos_y;
		priority if (cmd == bgl_pkg::CMD_START) begin
			entry.kind = bgl_pkg::KIND_START;
		end else if (cmd == bgl_pkg::CMD_TABLE) begin
			entry.kind = bgl_pkg::KIND_TABLE;
			entry.code = table_index;
		end else if (char_code == bgl_pkg::NEWLINE_CODE) begin
			entry.kind = bgl_pkg::KIND_NEWLINE;
		end else if (in_range) begin
			entry.kind = bgl_pkg::KIND_GLYPH;
		end else begin
			entry.kind = bgl_pkg::KIND_SKIP;
		end
	end

endmodule

>>> rtl/core/bgl_queue.sv
// Two-entry queue of classified commands between front and back ends.
// Depends on bgl_pkg for the entry type.
module bgl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bgl_pkg::q_entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output bgl_pkg::q_entry_t head
);

	bgl_pkg::q_entry_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

>>> rtl/core/bgl_back.sv
// Back end: pen state, advance table, column/row divider and result register.
// Depends on bgl_pkg and bgl_ram; pops commands from bgl_queue.
module bgl_back #(
	parameter int ADVANCE_ENTRIES = 128,
	parameter int PEN_BITS        = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bgl_pkg::cfg_t      cfg,
	input  logic               q_valid,
	input  bgl_pkg::q_entry_t  q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [13:0]        src_x,
	output logic [13:0]        src_y,
	output logic [6:0]         src_w,
	output logic [6:0]         src_h,
	output logic signed [23:0] dst_x,
	output logic signed [23:0] dst_y,
	output logic [21:0]        dst_w,
	output logic [21:0]        dst_h
);

	localparam int AW    = $clog2(ADVANCE_ENTRIES);
	localparam int SUM_W = ((PEN_BITS > 25) ? PEN_BITS : 25) + 1;
	localparam logic signed [SUM_W-1:0] PEN_MAX =
		{{(SUM_W-PEN_BITS+1){1'b0}}, {(PEN_BITS-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] PEN_MIN = ~PEN_MAX;
	localparam logic signed [SUM_W-1:0] OUT_MAX = {{(SUM_W-23){1'b0}}, {23{1'b1}}};
	localparam logic signed [SUM_W-1:0] OUT_MIN = ~OUT_MAX;

	function automatic logic signed [PEN_BITS-1:0] sat_pen(input logic signed [SUM_W-1:0] v);
		logic signed [PEN_BITS-1:0] r;
		if (v > PEN_MAX) begin
			r = PEN_MAX[PEN_BITS-1:0];
		end else if (v < PEN_MIN) begin
			r = PEN_MIN[PEN_BITS-1:0];
		end else begin
			r = v[PEN_BITS-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [23:0] sat_out(input logic signed [SUM_W-1:0] v);
		logic signed [23:0] r;
		if (v > OUT_MAX) begin
			r = OUT_MAX[23:0];
		end else if (v < OUT_MIN) begin
			r = OUT_MIN[23:0];
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	// Restoring division, a few quotient bits per call. The dividend sits
	// in the quotient register and shifts out as quotient bits shift in.
	function automatic logic [16:0] div_steps(input logic [8:0] rem_in,
		input logic [7:0] quo_in, input logic [8:0] dvs);
		logic [8:0] r;
		logic [7:0] q;
		r = rem_in;
		q = quo_in;
		for (int i = 0; i < bgl_pkg::DIV_STEPS; i++) begin
			r = {r[7:0], q[7]};
			q = {q[6:0], 1'b0};
			if (r >= dvs) begin
				r    = r - dvs;
				q[0] = 1'b1;
			end
		end
		return {r, q};
	endfunction

	bgl_pkg::bk_state_t state_q, state_d;

	logic signed [PEN_BITS-1:0] pen_x_q, pen_y_q, line_x_q;
	logic [ADVANCE_ENTRIES-1:0] written_q;
	logic                       hit_q;
	logic [8:0]                 rem_q;
	logic [7:0]                 quo_q;
	logic [23:0]                adv_scaled_q;
	logic                       out_valid_q;

	logic             out_free;
	logic             emit;
	logic             div_run;
	logic             start_glyph;
	logic             ram_we;
	logic [7:0]       ram_rdata;
	logic [8:0]       divisor;
	logic [16:0]      div_next;
	logic [7:0]       adv_sel;

	logic signed [SUM_W-1:0] pen_x_ext, pen_y_ext;
	logic signed [SUM_W-1:0] pos_x_ext, pos_y_ext;
	logic signed [SUM_W-1:0] add_adv, add_width, add_height;

	assign out_free = !out_valid_q || out_ready;
	assign divisor  = (cfg.atlas_columns == 9'd0) ? 9'd1 : cfg.atlas_columns;
	assign div_next = div_steps(rem_q, quo_q, divisor);
	assign adv_sel  = hit_q ? ram_rdata : {1'b0, cfg.glyph_width};

	assign pen_x_ext  = SUM_W'(pen_x_q);
	assign pen_y_ext  = SUM_W'(pen_y_q);
	assign pos_x_ext  = SUM_W'(q_head.pos_x);
	assign pos_y_ext  = SUM_W'(q_head.pos_y);
	assign add_adv    = signed'({{(SUM_W-24){1'b0}}, adv_scaled_q});
	assign add_width  = signed'({{(SUM_W-23){1'b0}}, cfg.width_scaled});
	assign add_height = signed'({{(SUM_W-23){1'b0}}, cfg.height_scaled});

	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		emit        = 1'b0;
		div_run     = 1'b0;
		start_glyph = 1'b0;
		ram_we      = 1'b0;
		unique case (state_q)
			bgl_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_head.kind == bgl_pkg::KIND_GLYPH) begin
						start_glyph = 1'b1;
						state_d     = bgl_pkg::BK_DIV_A;
					end
					if (q_head.kind == bgl_pkg::KIND_TABLE) begin
						ram_we = 1'b1;
					end
				end
			end
			bgl_pkg::BK_DIV_A: begin
				div_run = 1'b1;
				state_d = bgl_pkg::BK_DIV_B;
			end
			bgl_pkg::BK_DIV_B: begin
				div_run = 1'b1;
				state_d = bgl_pkg::BK_EMIT;
			end
			bgl_pkg::BK_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = bgl_pkg::BK_IDLE;
				end
			end
			default: state_d = bgl_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bgl_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Pen, line origin, written bits and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			line_x_q    <= '0;
			written_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				unique case (q_head.kind)
					bgl_pkg::KIND_START: begin
						pen_x_q  <= sat_pen(pos_x_ext);
						pen_y_q  <= sat_pen(pos_y_ext);
						line_x_q <= sat_pen(pos_x_ext);
					end
					bgl_pkg::KIND_TABLE: begin
						written_q[AW'(q_head.code)] <= 1'b1;
					end
					bgl_pkg::KIND_NEWLINE: begin
						pen_x_q <= line_x_q;
						pen_y_q <= sat_pen(pen_y_ext + add_height);
					end
					bgl_pkg::KIND_SKIP: begin
						pen_x_q <= sat_pen(pen_x_ext + add_width);
					end
					default: begin
					end
				endcase
			end
			if (emit) begin
				pen_x_q     <= sat_pen(pen_x_ext + add_adv);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Divider, advance product and result payload.
	always_ff @(posedge clk) begin
		if (start_glyph) begin
			rem_q <= 9'd0;
			quo_q <= {1'b0, q_head.idx};
			hit_q <= written_q[AW'(q_head.code)];
		end
		if (div_run) begin
			rem_q <= div_next[16:8];
			quo_q <= div_next[7:0];
		end
		if (state_q == bgl_pkg::BK_DIV_A) begin
			adv_scaled_q <= 24'(adv_sel) * 24'(cfg.draw_scale);
		end
		if (emit) begin
			src_x <= 14'(rem_q[6:0]) * 14'(cfg.glyph_width);
			src_y <= 14'(quo_q[6:0]) * 14'(cfg.glyph_height);
			src_w <= cfg.glyph_width;
			src_h <= cfg.glyph_height;
			dst_x <= sat_out(pen_x_ext);
			dst_y <= sat_out(pen_y_ext);
			dst_w <= cfg.width_scaled[22] ? {22{1'b1}} : cfg.width_scaled[21:0];
			dst_h <= cfg.height_scaled[22] ? {22{1'b1}} : cfg.height_scaled[21:0];
		end
	end

	assign out_valid = out_valid_q;

	bgl_ram #(
		.WIDTH(8),
		.DEPTH(ADVANCE_ENTRIES)
	) u_advance_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(q_head.code)),
		.wdata(q_head.adv),
		.re   (start_glyph),
		.raddr(AW'(q_head.code)),
		.rdata(ram_rdata)
	);

endmodule

>>> rtl/core/bitmap_glyph_layout_core.sv
// Top level of the bitmap glyph layout block: configuration registers,
// front end, command queue and back end. Depends on bgl_pkg and all bgl_* modules.
//
// Usage. Commands arrive on the in_valid/in_ready channel: start (sets pen
// and line origin), character, and advance table write. Each drawn glyph
// leaves as one transfer on the out_valid/out_ready channel carrying the
// atlas source rectangle and the scaled screen rectangle. Newlines, codes
// outside the atlas, table writes and start commands make no result; an
// unknown command is taken and dropped.
// The back-end sequencer takes each glyph through the advance RAM read,
// the DIV_A and DIV_B states of the four-bit-per-cycle column/row divider
// and the result load, popping no new command meanwhile; any other command
// is finished as it is popped. The front end takes a new transfer every
// cycle while the two-entry queue has room, so input keeps flowing while
// a result waits on a stalled receiver; the back end holds its finished
// glyph until the result register frees. Reset clears the pen, the line
// origin and every advance written bit at once (no clearing pass) and
// restores register defaults. Registers are APB writable at byte address
// 4*index; the user must write them only while idle, unchecked by the block.
module bitmap_glyph_layout_core #(
	parameter int ADVANCE_ENTRIES = 128,
	parameter int PEN_BITS        = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [7:0]         char_code,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic [6:0]         table_index,
	input  logic [7:0]         advance_width,
	// Result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [13:0]        src_x,
	output logic [13:0]        src_y,
	output logic [6:0]         src_w,
	output logic [6:0]         src_h,
	output logic signed [23:0] dst_x,
	output logic signed [23:0] dst_y,
	output logic [21:0]        dst_w,
	output logic [21:0]        dst_h
);

	logic [6:0]  glyph_width_q;
	logic [6:0]  glyph_height_q;
	logic [7:0]  first_code_q;
	logic [8:0]  glyph_count_q;
	logic [8:0]  atlas_columns_q;
	logic [15:0] draw_scale_q;
	logic [22:0] width_scaled_q;
	logic [22:0] height_scaled_q;

	logic              cfg_write;
	logic [2:0]        reg_index;
	bgl_pkg::cfg_t     cfg;
	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_valid;
	bgl_pkg::q_entry_t q_in;
	bgl_pkg::q_entry_t q_head;

	assign pready    = 1'b1;
	assign reg_index = paddr[4:2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q   <= bgl_pkg::RST_GLYPH_WIDTH;
			glyph_height_q  <= bgl_pkg::RST_GLYPH_HEIGHT;
			first_code_q    <= bgl_pkg::RST_FIRST_CODE;
			glyph_count_q   <= bgl_pkg::RST_GLYPH_COUNT;
			atlas_columns_q <= bgl_pkg::RST_ATLAS_COLUMNS;
			draw_scale_q    <= bgl_pkg::RST_DRAW_SCALE;
		end else if (cfg_write) begin
			unique case (reg_index)
				bgl_pkg::REG_GLYPH_WIDTH:   glyph_width_q   <= pwdata[6:0];
				bgl_pkg::REG_GLYPH_HEIGHT:  glyph_height_q  <= pwdata[6:0];
				bgl_pkg::REG_FIRST_CODE:    first_code_q    <= pwdata[7:0];
				bgl_pkg::REG_GLYPH_COUNT:   glyph_count_q   <= pwdata[8:0];
				bgl_pkg::REG_ATLAS_COLUMNS: atlas_columns_q <= pwdata[8:0];
				bgl_pkg::REG_DRAW_SCALE:    draw_scale_q    <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// The scaled cell sizes are registered, so they follow the registers
	// in the cycle after a change.
	always_ff @(posedge clk) begin
		width_scaled_q  <= 23'(glyph_width_q) * 23'(draw_scale_q);
		height_scaled_q <= 23'(glyph_height_q) * 23'(draw_scale_q);
	end

	always_comb begin
		unique case (reg_index)
			bgl_pkg::REG_GLYPH_WIDTH:   prdata = {25'd0, glyph_width_q};
			bgl_pkg::REG_GLYPH_HEIGHT:  prdata = {25'd0, glyph_height_q};
			bgl_pkg::REG_FIRST_CODE:    prdata = {24'd0, first_code_q};
			bgl_pkg::REG_GLYPH_COUNT:   prdata = {23'd0, glyph_count_q};
			bgl_pkg::REG_ATLAS_COLUMNS: prdata = {23'd0, atlas_columns_q};
			bgl_pkg::REG_DRAW_SCALE:    prdata = {16'd0, draw_scale_q};
			default:                    prdata = 32'd0;
		endcase
	end

	always_comb begin
		cfg.glyph_width   = glyph_width_q;
		cfg.glyph_height  = glyph_height_q;
		cfg.first_code    = first_code_q;
		cfg.glyph_count   = glyph_count_q;
		cfg.atlas_columns = atlas_columns_q;
		cfg.draw_scale    = draw_scale_q;
		cfg.width_scaled  = width_scaled_q;
		cfg.height_scaled = height_scaled_q;
	end

	bgl_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.char_code    (char_code),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.table_index  (table_index),
		.advance_width(advance_width),
		.cfg          (cfg),
		.q_full       (q_full),
		.push         (q_push),
		.entry        (q_in)
	);

	bgl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	bgl_back #(
		.ADVANCE_ENTRIES(ADVANCE_ENTRIES),
		.PEN_BITS       (PEN_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.src_x    (src_x),
		.src_y    (src_y),
		.src_w    (src_w),
		.src_h    (src_h),
		.dst_x    (dst_x),
		.dst_y    (dst_y),
		.dst_w    (dst_w),
		.dst_h    (dst_h)
	);

endmodule

>>> sim/bitmap_glyph_layout_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_glyph_layout_core: a directed table, then fixed and
// random layout settings with random command streams, checked against hand-worked results
// or an in-bench pen and atlas model. Depends on bgl_pkg and the core RTL only.
module bitmap_glyph_layout_core_tb;

	// Command code 3 is not defined; the block must take and drop it.
	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	// Word index with no register behind it.
	localparam logic [2:0] REG_UNMAPPED = 3'd7;

	localparam logic signed [23:0] PEN_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] PEN_MIN = 24'sh800000;
	localparam longint PEN_HI = 64'sd8388607;
	localparam longint PEN_LO = -64'sd8388608;

	// The back end holds at most two queued commands plus one result, so
	// this is ample time for it to go quiet.
	localparam int SETTLE_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT = 200_000;

	// One drawn glyph as it leaves on the result channel.
	typedef struct packed {
		logic [13:0]        src_x;
		logic [13:0]        src_y;
		logic [6:0]         src_w;
		logic [6:0]         src_h;
		logic signed [23:0] dst_x;
		logic signed [23:0] dst_y;
		logic [21:0]        dst_w;
		logic [21:0]        dst_h;
	} glyph_rect_t;

	localparam glyph_rect_t NO_RECT = '0;
	// Scaled cell size under the reset settings (8x12 cells, scale 1.0).
	localparam logic [21:0] CELL_W0 = 22'd2048;
	localparam logic [21:0] CELL_H0 = 22'd3072;
	localparam logic signed [23:0] LINE1_Y = 24'sd3072;

	typedef struct {
		logic [1:0]         op;
		logic [7:0]         code;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic [6:0]         ti;
		logic [7:0]         aw;
		bit                 typed;
		glyph_rect_t        want;
	} stim_row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         cmd = bgl_pkg::CMD_START;
	logic [7:0]         char_code = '0;
	logic signed [23:0] pos_x = '0;
	logic signed [23:0] pos_y = '0;
	logic [6:0]         table_index = '0;
	logic [7:0]         advance_width = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [13:0]        src_x;
	logic [13:0]        src_y;
	logic [6:0]         src_w;
	logic [6:0]         src_h;
	logic signed [23:0] dst_x;
	logic signed [23:0] dst_y;
	logic [21:0]        dst_w;
	logic [21:0]        dst_h;

	bitmap_glyph_layout_core dut (.*);

	// Shadow of the configuration registers, at their register widths.
	logic [6:0]  cfg_w     = bgl_pkg::RST_GLYPH_WIDTH;
	logic [6:0]  cfg_h     = bgl_pkg::RST_GLYPH_HEIGHT;
	logic [7:0]  cfg_first = bgl_pkg::RST_FIRST_CODE;
	logic [8:0]  cfg_count = bgl_pkg::RST_GLYPH_COUNT;
	logic [8:0]  cfg_cols  = bgl_pkg::RST_ATLAS_COLUMNS;
	logic [15:0] cfg_scale = bgl_pkg::RST_DRAW_SCALE;

	// Pen state of the model: current pen, and the x that a newline returns to.
	longint     cur_x = 0;
	longint     cur_y = 0;
	longint     margin_x = 0;
	logic [7:0] adv_tab [0:127];
	bit         adv_known [0:127] = '{default: 1'b0};

	glyph_rect_t pending_glyphs [$];
	glyph_rect_t seen;
	glyph_rect_t oldest;
	bit          steady = 1'b0;
	int          fail_count = 0;
	int          glyphs_checked = 0;
	int          items_sent = 0;
	int          settings_run = 1;
	int unsigned cycles = 0;

	// Directed table. Rows with typed set carry a result worked out by hand
	// from the reset settings; the rest are checked against the model.
	stim_row_t dir_rows [25] = '{
		// First glyphs after reset: 'A', space, and the last cell of the atlas.
		'{bgl_pkg::CMD_CHAR, 8'd65, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b1,
			'{14'd8, 14'd24, 7'd8, 7'd12, 24'sd0, 24'sd0, CELL_W0, CELL_H0}},
		'{bgl_pkg::CMD_CHAR, 8'd32, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b1,
			'{14'd0, 14'd0, 7'd8, 7'd12, 24'sd2048, 24'sd0, CELL_W0, CELL_H0}},
		'{bgl_pkg::CMD_CHAR, 8'd127, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b1,
			'{14'd120, 14'd60, 7'd8, 7'd12, 24'sd4096, 24'sd0, CELL_W0, CELL_H0}},
		// Below the first code, and two bytes that read as negative chars.
		'{bgl_pkg::CMD_CHAR, 8'd31, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b0, NO_RECT},
		'{bgl_pkg::CMD_CHAR, 8'd128, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b0, NO_RECT},
		'{bgl_pkg::CMD_CHAR, 8'd255, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b0, NO_RECT},
		'{bgl_pkg::CMD_CHAR, bgl_pkg::NEWLINE_CODE, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b0,
			NO_RECT},
		// Undefined command with a table write payload: must change nothing.
		'{CMD_UNUSED, 8'hFF, PEN_MIN, PEN_MAX, 7'h7F, 8'hFF, 1'b0, NO_RECT},
		// Zero advance for 'B': the pen must not move across two of them.
		'{bgl_pkg::CMD_TABLE, 8'd0, 24'sd0, 24'sd0, 7'd66, 8'd0, 1'b0, NO_RECT},
		'{bgl_pkg::CMD_CHAR, 8'd66, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b1,
			'{14'd16, 14'd24, 7'd8, 7'd12, 24'sd0, LINE1_Y, CELL_W0, CELL_H0}},
		'{bgl_pkg::CMD_CHAR, 8'd66, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b1,
			'{14'd16, 14'd24, 7'd8, 7'd12, 24'sd0, LINE1_Y, CELL_W0, CELL_H0}},
		// Code 127 still unwritten, then the widest advance on it.
		'{bgl_pkg::CMD_CHAR, 8'd127, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b1,
			'{14'd120, 14'd60, 7'd8, 7'd12, 24'sd0, LINE1_Y, CELL_W0, CELL_H0}},
		'{bgl_pkg::CMD_TABLE, 8'd0, 24'sd0, 24'sd0, 7'd127, 8'd255, 1'b0, NO_RECT},
		'{bgl_pkg::CMD_CHAR, 8'd127, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b1,
			'{14'd120, 14'd60, 7'd8, 7'd12, 24'sd2048, LINE1_Y, CELL_W0, CELL_H0}},
		// Origin at the top of the pen range: advances and newlines saturate.
		'{bgl_pkg::CMD_START, 8'd0, PEN_MAX, PEN_MAX, 7'd0, 8'd0, 1'b0, NO_RECT},
		'{bgl_pkg::CMD_CHAR, 8'd65, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b1,
			'{14'd8, 14'd24, 7'd8, 7'd12, PEN_MAX, PEN_MAX, CELL_W0, CELL_H0}},
		'{bgl_pkg::CMD_CHAR, 8'd65, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b1,
			'{14'd8, 14'd24, 7'd8, 7'd12, PEN_MAX, PEN_MAX, CELL_W0, CELL_H0}},
		'{bgl_pkg::CMD_CHAR, bgl_pkg::NEWLINE_CODE, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b0,
			NO_RECT},
		'{bgl_pkg::CMD_CHAR, 8'd32, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b1,
			'{14'd0, 14'd0, 7'd8, 7'd12, PEN_MAX, PEN_MAX, CELL_W0, CELL_H0}},
		// Origin at the bottom of the range.
		'{bgl_pkg::CMD_START, 8'd0, PEN_MIN, PEN_MIN, 7'd0, 8'd0, 1'b0, NO_RECT},
		'{bgl_pkg::CMD_CHAR, 8'd255, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b0, NO_RECT},
		'{bgl_pkg::CMD_CHAR, 8'd33, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b0, NO_RECT},
		// Alternating bit patterns through the table port.
		'{bgl_pkg::CMD_TABLE, 8'd0, 24'sd0, 24'sd0, 7'h55, 8'hAA, 1'b0, NO_RECT},
		'{bgl_pkg::CMD_TABLE, 8'd0, 24'sd0, 24'sd0, 7'h2A, 8'h55, 1'b0, NO_RECT},
		'{bgl_pkg::CMD_CHAR, 8'h55, 24'sd0, 24'sd0, 7'd0, 8'd0, 1'b0, NO_RECT}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint clamp_pen(longint v);
		return v > PEN_HI ? PEN_HI : (v < PEN_LO ? PEN_LO : v);
	endfunction

	function automatic longint clamp_field(longint v, int bits);
		longint hi;
		hi = (longint'(1) << bits) - 1;
		return v > hi ? hi : v;
	endfunction

	// Applies one accepted command to the pen model. Returns 1 when the
	// command draws a glyph, with the glyph's rectangles in r.
	function automatic bit layout_step(input logic [1:0] op, input logic [7:0] code,
			input logic signed [23:0] px, input logic signed [23:0] py,
			input logic [6:0] ti, input logic [7:0] aw, output glyph_rect_t r);
		longint sc, idx, cols, gw, gh, scale, step;
		bit drawn;
		drawn = 1'b0;
		r = NO_RECT;
		gw = longint'(cfg_w);
		gh = longint'(cfg_h);
		scale = longint'(cfg_scale);
		case (op)
			bgl_pkg::CMD_START: begin
				cur_x = clamp_pen(longint'(px));
				cur_y = clamp_pen(longint'(py));
				margin_x = cur_x;
			end
			bgl_pkg::CMD_TABLE: begin
				adv_tab[ti] = aw;
				adv_known[ti] = 1'b1;
			end
			bgl_pkg::CMD_CHAR: begin
				if (code == bgl_pkg::NEWLINE_CODE) begin
					cur_x = margin_x;
					cur_y = clamp_pen(cur_y + gh * scale);
				end else begin
					// The byte is a signed char, so 128..255 land below zero.
					sc = (code < 8'd128) ? longint'(code) : longint'(code) - 256;
					idx = sc - longint'(cfg_first);
					if (idx >= 0 && idx < longint'(cfg_count)) begin
						cols = (cfg_cols == '0) ? 1 : longint'(cfg_cols);
						r.src_x = 14'(clamp_field((idx % cols) * gw, 14));
						r.src_y = 14'(clamp_field((idx / cols) * gh, 14));
						r.src_w = cfg_w;
						r.src_h = cfg_h;
						r.dst_x = 24'(cur_x);
						r.dst_y = 24'(cur_y);
						r.dst_w = 22'(clamp_field(gw * scale, 22));
						r.dst_h = 22'(clamp_field(gh * scale, 22));
						step = adv_known[sc[6:0]] ? longint'(adv_tab[sc[6:0]]) : gw;
						cur_x = clamp_pen(cur_x + step * scale);
						drawn = 1'b1;
					end else begin
						cur_x = clamp_pen(cur_x + gw * scale);
					end
				end
			end
			default: ;
		endcase
		return drawn;
	endfunction

	function automatic string rect_str(glyph_rect_t g);
		return $sformatf("src=(%0d,%0d) %0dx%0d dst=(%0d,%0d) %0dx%0d", g.src_x, g.src_y,
			g.src_w, g.src_h, g.dst_x, g.dst_y, g.dst_w, g.dst_h);
	endfunction

	function automatic void note_fail(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("MISMATCH: %s", msg);
	endfunction

	function automatic logic signed [23:0] rand_pos();
		case ($urandom_range(0, 39))
			0: return PEN_MAX;
			1: return PEN_MIN;
			2: return 24'sd0;
			3: return -24'sd1;
			default: return 24'($urandom());
		endcase
	endfunction

	// One input transfer. The sender idles at random first, unless the
	// steady stretch is on. The model is advanced at the accepting edge.
	task automatic push_item(input logic [1:0] op, input logic [7:0] code,
			input logic signed [23:0] px, input logic signed [23:0] py,
			input logic [6:0] ti, input logic [7:0] aw, input bit typed,
			input glyph_rect_t want);
		glyph_rect_t r;
		bit drawn;
		while (!steady && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= op;
		char_code     <= code;
		pos_x         <= px;
		pos_y         <= py;
		table_index   <= ti;
		advance_width <= aw;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		drawn = layout_step(op, code, px, py, ti, aw, r);
		if (drawn)
			pending_glyphs.push_back(typed ? want : r);
	endtask

	// A random command stream under the current settings. Most characters
	// fall inside the atlas so that results stay frequent.
	task automatic run_random(input int n);
		logic [1:0] op;
		logic [7:0] code;
		int pick, span;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				op = bgl_pkg::CMD_START;
			else if (pick < 18)
				op = bgl_pkg::CMD_TABLE;
			else if (pick < 21)
				op = CMD_UNUSED;
			else
				op = bgl_pkg::CMD_CHAR;
			span = 0;
			if (cfg_first < 8'd128 && cfg_count != '0)
				span = (int'(cfg_count) < 128 - int'(cfg_first)) ?
					int'(cfg_count) : 128 - int'(cfg_first);
			pick = $urandom_range(0, 99);
			if (pick < 60 && span > 0)
				code = cfg_first + 8'($urandom_range(0, span - 1));
			else if (pick < 70)
				code = bgl_pkg::NEWLINE_CODE;
			else
				code = 8'($urandom());
			push_item(op, code, rand_pos(), rand_pos(), 7'($urandom()), 8'($urandom()),
				1'b0, NO_RECT);
		end
		in_valid <= 1'b0;
	endtask

	// Setup and access cycle on the configuration port, then psel stays low
	// so that back-to-back transfers never touch psel twice in one step.
	task automatic apb_xfer(input logic [2:0] idx, input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] wdata);
		logic [31:0] unused;
		apb_xfer(idx, 1'b1, wdata, unused);
		case (idx)
			bgl_pkg::REG_GLYPH_WIDTH:   cfg_w = wdata[6:0];
			bgl_pkg::REG_GLYPH_HEIGHT:  cfg_h = wdata[6:0];
			bgl_pkg::REG_FIRST_CODE:    cfg_first = wdata[7:0];
			bgl_pkg::REG_GLYPH_COUNT:   cfg_count = wdata[8:0];
			bgl_pkg::REG_ATLAS_COLUMNS: cfg_cols = wdata[8:0];
			bgl_pkg::REG_DRAW_SCALE:    cfg_scale = wdata[15:0];
			default: ;
		endcase
	endtask

	// Writes all six registers with junk above each register's width, which
	// the block must drop, then reads every register back.
	task automatic set_layout(input logic [6:0] gw, input logic [6:0] gh,
			input logic [7:0] first, input logic [8:0] count, input logic [8:0] cols,
			input logic [15:0] scale);
		logic [31:0] rd, want;
		reg_write(bgl_pkg::REG_GLYPH_WIDTH, ($urandom() << 7) | 32'(gw));
		reg_write(bgl_pkg::REG_GLYPH_HEIGHT, ($urandom() << 7) | 32'(gh));
		reg_write(bgl_pkg::REG_FIRST_CODE, ($urandom() << 8) | 32'(first));
		reg_write(bgl_pkg::REG_GLYPH_COUNT, ($urandom() << 9) | 32'(count));
		reg_write(bgl_pkg::REG_ATLAS_COLUMNS, ($urandom() << 9) | 32'(cols));
		reg_write(bgl_pkg::REG_DRAW_SCALE, ($urandom() << 16) | 32'(scale));
		for (int k = bgl_pkg::REG_GLYPH_WIDTH; k <= bgl_pkg::REG_DRAW_SCALE; k++) begin
			apb_xfer(3'(k), 1'b0, 32'($urandom()), rd);
			case (3'(k))
				bgl_pkg::REG_GLYPH_WIDTH:   want = 32'(cfg_w);
				bgl_pkg::REG_GLYPH_HEIGHT:  want = 32'(cfg_h);
				bgl_pkg::REG_FIRST_CODE:    want = 32'(cfg_first);
				bgl_pkg::REG_GLYPH_COUNT:   want = 32'(cfg_count);
				bgl_pkg::REG_ATLAS_COLUMNS: want = 32'(cfg_cols);
				default:                    want = 32'(cfg_scale);
			endcase
			if (rd !== want)
				note_fail($sformatf("register %0d read back %0h, expected %0h", k, rd, want));
		end
		settings_run++;
	endtask

	// Waits for the last expected glyph, then lets the back end finish any
	// command that draws nothing before the settings may change.
	task automatic wait_drain();
		while (pending_glyphs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The receiver stalls in about one cycle of eight, except during the
	// steady stretch, where it takes every result at once.
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(0, 99) >= 12);

	// Result checker. Signals are read right after the edge, so the values
	// seen are the ones the edge sampled.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen = {src_x, src_y, src_w, src_h, dst_x, dst_y, dst_w, dst_h};
			if (pending_glyphs.size() == 0) begin
				note_fail($sformatf("result with nothing expected: %s", rect_str(seen)));
			end else begin
				oldest = pending_glyphs.pop_front();
				glyphs_checked++;
				if (seen !== oldest)
					note_fail($sformatf("glyph %0d expected %s, got %s", glyphs_checked,
						rect_str(oldest), rect_str(seen)));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d glyphs outstanding", cycles,
				pending_glyphs.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset settings; nothing is written first,
		// so the typed rows also confirm the register defaults.
		foreach (dir_rows[i])
			push_item(dir_rows[i].op, dir_rows[i].code, dir_rows[i].px, dir_rows[i].py,
				dir_rows[i].ti, dir_rows[i].aw, dir_rows[i].typed, dir_rows[i].want);
		run_random(150);

		// Smallest legal cells, columns and scale: one glyph per atlas row.
		wait_drain();
		set_layout(7'd1, 7'd1, 8'd0, 9'd256, 9'd1, 16'd1);
		run_random(130);

		// Largest legal values. A first code of 255 is beyond every signed
		// char, so only starts, newlines and skipped codes move the pen here.
		wait_drain();
		set_layout(7'd64, 7'd64, 8'd255, 9'd1, 9'd256, 16'd65535);
		run_random(40);

		// Full field values: the scaled size saturates, zero columns act as
		// one. A write to an unmapped address goes first and must be lost.
		wait_drain();
		reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
		set_layout(7'd127, 7'd127, 8'd0, 9'd511, 9'd0, 16'd65535);
		run_random(130);

		// Zero-sized cells and zero scale: only start commands move the pen.
		wait_drain();
		set_layout(7'd0, 7'd0, 8'd100, 9'd28, 9'd5, 16'd0);
		run_random(130);

		// Random settings. The middle one runs with neither side idling.
		for (int p = 0; p < 3; p++) begin
			wait_drain();
			set_layout(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
				8'($urandom_range(0, 120)), 9'($urandom_range(1, 256)),
				9'($urandom_range(1, 256)),
				16'($urandom_range(0, 1) ? $urandom_range(1, 1024) : $urandom_range(1, 65535)));
			steady = (p == 1);
			run_random(p == 1 ? 170 : 150);
			steady = 1'b0;
		end

		wait_drain();
		$display("Sent %0d commands under %0d register settings and checked %0d glyphs,",
			items_sent, settings_run, glyphs_checked);
		$display("including newlines, skipped and negative codes and pen saturation; %0d errors.",
			fail_count);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
